[rtl/obfifo_pkg.sv]
`timescale 1ns / 1ps

package obfifo_pkg;

   // Input item kinds.
   typedef enum logic [1:0] {
      REQ_ARRIVAL = 2'd0,
      REQ_READ    = 2'd1,
      REQ_INFO    = 2'd2
   } req_kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      RSP_DATA        = 3'd0,
      RSP_PARKED      = 3'd1,
      RSP_WOULD_BLOCK = 3'd2,
      RSP_BUSY        = 3'd3,
      RSP_INFO        = 3'd4
   } rsp_status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ARRIVE,
      OP_DRAIN_START,
      OP_PARK,
      OP_RESULT,
      OP_INFO,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type      op;
      rsp_status_type code;
   } cmd_type;

   typedef struct packed {
      logic pending;
      logic empty;
      logic last;
   } dp_stat_type;

   localparam int CFG_W      = 9;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 7;
   localparam int RING_MAX   = 256;
   localparam int RING_MIN   = 2;

endpackage

[rtl/obfifo_ifs.sv]
`timescale 1ns / 1ps

interface obfifo_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] data_byte;
   logic [6:0] read_len;
   logic       nonblock;

   modport source (output valid, req_type, data_byte, read_len, nonblock, input ready);
   modport sink   (input valid, req_type, data_byte, read_len, nonblock, output ready);
endinterface

interface obfifo_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] out_byte;
   logic       last;
   logic [7:0] used_count;
   logic       overflow_seen;

   modport source (output valid, status, out_byte, last, used_count, overflow_seen,
                   input ready);
   modport sink   (input valid, status, out_byte, last, used_count, overflow_seen,
                   output ready);
endinterface

[rtl/obfifo_ram.sv]
`timescale 1ns / 1ps

module obfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/obfifo_ctrl.sv]
`timescale 1ns / 1ps

module obfifo_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_kind,
   input  logic                    req_nonblock,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output obfifo_pkg::cmd_type     cmd,
   input  obfifo_pkg::dp_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_LOAD  = 4'b0100,
      S_SEND  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           req_fire;
   logic           rsp_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = obfifo_pkg::OP_NONE;
      cmd.code  = obfifo_pkg::RSP_DATA;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority if (req_kind == obfifo_pkg::REQ_ARRIVAL) begin
                  cmd.op = obfifo_pkg::OP_ARRIVE;
                  // A parked read is answered right after the byte lands.
                  if (stat.pending) begin
                     state_in = S_FETCH;
                  end
               end else if (req_kind == obfifo_pkg::REQ_READ) begin
                  if (stat.pending) begin
                     cmd.op   = obfifo_pkg::OP_RESULT;
                     cmd.code = obfifo_pkg::RSP_BUSY;
                     state_in = S_SEND;
                  end else if (stat.empty) begin
                     if (req_nonblock) begin
                        cmd.op   = obfifo_pkg::OP_RESULT;
                        cmd.code = obfifo_pkg::RSP_WOULD_BLOCK;
                     end else begin
                        cmd.op   = obfifo_pkg::OP_PARK;
                        cmd.code = obfifo_pkg::RSP_PARKED;
                     end
                     state_in = S_SEND;
                  end else begin
                     cmd.op   = obfifo_pkg::OP_DRAIN_START;
                     state_in = S_FETCH;
                  end
               end else if (req_kind == obfifo_pkg::REQ_INFO) begin
                  cmd.op   = obfifo_pkg::OP_INFO;
                  cmd.code = obfifo_pkg::RSP_INFO;
                  state_in = S_SEND;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op   = obfifo_pkg::OP_LOAD;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_fire) begin
               state_in = stat.last ? S_IDLE : S_LOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_arrival_wakes_parked_read: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == obfifo_pkg::REQ_ARRIVAL && stat.pending)
         |=> (state_ff == S_FETCH))
      else $error("arrival with a parked read did not start a drain");

   a_load_then_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (state_ff == S_SEND))
      else $error("loaded byte was not offered");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("offered result withdrawn before it was taken");

endmodule

[rtl/obfifo_dp.sv]
`timescale 1ns / 1ps

module obfifo_dp #(
   parameter int DEPTH    = 256,
   parameter int MAX_READ = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  obfifo_pkg::cmd_type                  cmd,
   output obfifo_pkg::dp_stat_type              stat,
   input  logic [obfifo_pkg::BYTE_W-1:0]        data_byte,
   input  logic [obfifo_pkg::LEN_W-1:0]         read_len,
   input  logic                                 csr_we,
   input  logic [obfifo_pkg::CFG_W-1:0]         csr_wdata,
   output logic [2:0]                           status,
   output logic [obfifo_pkg::BYTE_W-1:0]        out_byte,
   output logic                                 last,
   output logic [obfifo_pkg::BYTE_W-1:0]        used_count,
   output logic                                 overflow_seen
);

   localparam int TOP_INT = (DEPTH < obfifo_pkg::RING_MAX) ? DEPTH : obfifo_pkg::RING_MAX;
   localparam int IDX_W   = $clog2(TOP_INT);
   localparam logic [obfifo_pkg::CFG_W-1:0] TOP = obfifo_pkg::CFG_W'(TOP_INT);
   localparam logic [obfifo_pkg::CFG_W-1:0] LOW = obfifo_pkg::CFG_W'(obfifo_pkg::RING_MIN);
   localparam logic [obfifo_pkg::LEN_W-1:0] LEN_TOP = obfifo_pkg::LEN_W'(MAX_READ);

   logic [obfifo_pkg::CFG_W-1:0]  fifo_size_ff, fifo_size_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              tail_ff, tail_in;
   logic                          ovf_ff, ovf_in;
   logic                          pend_ff, pend_in;
   logic [obfifo_pkg::LEN_W-1:0]  pend_len_ff, pend_len_in;
   logic [obfifo_pkg::LEN_W-1:0]  rem_ff, rem_in;

   logic [2:0]                    status_ff, status_in;
   logic [obfifo_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                          last_ff, last_in;
   logic [obfifo_pkg::BYTE_W-1:0] used_ff, used_in;
   logic                          ovfs_ff, ovfs_in;

   logic [obfifo_pkg::CFG_W-1:0]  ring_len;
   logic [obfifo_pkg::LEN_W-1:0]  len_clamped;
   logic [IDX_W-1:0]              head_next;
   logic [IDX_W-1:0]              tail_next;
   logic [obfifo_pkg::CFG_W-1:0]  used_full;
   logic [obfifo_pkg::BYTE_W-1:0] ram_rd_data;
   logic                          ram_we;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                 input logic [obfifo_pkg::CFG_W-1:0] size);
      logic [obfifo_pkg::CFG_W-1:0] inc;
      inc = obfifo_pkg::CFG_W'(idx) + obfifo_pkg::CFG_W'(1);
      return (inc >= size) ? '0 : inc[IDX_W-1:0];
   endfunction

   always_comb begin
      if (fifo_size_ff < LOW) begin
         ring_len = LOW;
      end else if (fifo_size_ff > TOP) begin
         ring_len = TOP;
      end else begin
         ring_len = fifo_size_ff;
      end
   end

   always_comb begin
      if (read_len == '0) begin
         len_clamped = obfifo_pkg::LEN_W'(1);
      end else if (read_len > LEN_TOP) begin
         len_clamped = LEN_TOP;
      end else begin
         len_clamped = read_len;
      end
   end

   assign head_next = wrap_inc(head_ff, ring_len);
   assign tail_next = wrap_inc(tail_ff, ring_len);

   always_comb begin
      if (head_ff >= tail_ff) begin
         used_full = obfifo_pkg::CFG_W'(head_ff) - obfifo_pkg::CFG_W'(tail_ff);
      end else begin
         used_full = ring_len - obfifo_pkg::CFG_W'(tail_ff) + obfifo_pkg::CFG_W'(head_ff);
      end
   end

   assign ram_we = (cmd.op == obfifo_pkg::OP_ARRIVE);

   // The read port always follows tail through a register, so the byte at tail is ready in the next cycle.
   obfifo_ram #(
      .WIDTH (obfifo_pkg::BYTE_W),
      .DEPTH (TOP_INT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_ff),
      .wr_data (data_byte),
      .rd_addr (tail_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      fifo_size_in = fifo_size_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      pend_len_in  = pend_len_ff;
      rem_in       = rem_ff;
      status_in    = status_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      used_in      = used_ff;
      ovfs_in      = ovfs_ff;
      if (csr_we) begin
         // A new ring length empties the ring.
         fifo_size_in = csr_wdata;
         head_in      = '0;
         tail_in      = '0;
      end else begin
         unique case (cmd.op)
            obfifo_pkg::OP_ARRIVE: begin
               head_in = head_next;
               if (head_next == tail_ff) begin
                  tail_in = tail_next;
                  ovf_in  = 1'b1;
               end
               if (pend_ff) begin
                  rem_in      = pend_len_ff;
                  pend_in     = 1'b0;
                  pend_len_in = '0;
               end
            end
            obfifo_pkg::OP_DRAIN_START: begin
               rem_in = len_clamped;
            end
            obfifo_pkg::OP_PARK, obfifo_pkg::OP_RESULT, obfifo_pkg::OP_INFO: begin
               status_in = cmd.code;
               byte_in   = '0;
               last_in   = 1'b1;
               used_in   = '0;
               ovfs_in   = 1'b0;
               if (cmd.op == obfifo_pkg::OP_PARK) begin
                  pend_in     = 1'b1;
                  pend_len_in = len_clamped;
               end
               if (cmd.op == obfifo_pkg::OP_INFO) begin
                  used_in = used_full[obfifo_pkg::BYTE_W-1:0];
                  ovfs_in = ovf_ff;
                  ovf_in  = 1'b0;
               end
            end
            obfifo_pkg::OP_LOAD: begin
               status_in = obfifo_pkg::RSP_DATA;
               byte_in   = ram_rd_data;
               last_in   = (rem_ff == obfifo_pkg::LEN_W'(1)) || (tail_next == head_ff);
               used_in   = '0;
               ovfs_in   = 1'b0;
               tail_in   = tail_next;
               rem_in    = rem_ff - obfifo_pkg::LEN_W'(1);
            end
            obfifo_pkg::OP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_size_ff <= obfifo_pkg::CFG_W'(obfifo_pkg::RING_MAX);
         head_ff      <= '0;
         tail_ff      <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         pend_len_ff  <= '0;
         rem_ff       <= '0;
      end else begin
         fifo_size_ff <= fifo_size_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         pend_len_ff  <= pend_len_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      used_ff   <= used_in;
      ovfs_ff   <= ovfs_in;
   end

   assign stat.pending  = pend_ff;
   assign stat.empty    = (head_ff == tail_ff);
   assign stat.last     = last_ff;
   assign status        = status_ff;
   assign out_byte      = byte_ff;
   assign last          = last_ff;
   assign used_count    = used_ff;
   assign overflow_seen = ovfs_ff;

   a_arrival_leaves_data: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == obfifo_pkg::OP_ARRIVE && !csr_we) |=> (head_ff != tail_ff))
      else $error("ring reads empty right after a byte arrived");

   a_load_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == obfifo_pkg::OP_LOAD) |-> (head_ff != tail_ff))
      else $error("byte taken from an empty ring");

   a_index_in_ring: assert property (@(posedge clock) disable iff (reset)
      (obfifo_pkg::CFG_W'(head_ff) < ring_len) && (obfifo_pkg::CFG_W'(tail_ff) < ring_len))
      else $error("ring index beyond ring length");

   a_drain_clears_park: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == obfifo_pkg::OP_ARRIVE && !csr_we && pend_ff) |=> !pend_ff)
      else $error("parked read survived its answering byte");

endmodule

[rtl/overwrite_byte_fifo_with_blocking_read.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake     Payload
// req_ch    in         valid/ready   req_type, data_byte, read_len, nonblock
// rsp_ch    out        valid/ready   status, out_byte, last, used_count, overflow_seen
// csr       in         csr_we        csr_wdata (ring length, 9 bits)
//
// One item is in work at a time; req_ch.ready is high only when nothing is in work.
// An arrival is taken in idle and starts the drain of a parked read, if any; info
// and single-status reads wait in send until taken. A data read passes fetch, load and
// send to its first byte, then load and send per byte; the read port is registered.
// Reset is synchronous; the byte store has no clearing pass and needs none.
// A stalled rsp_ch holds the result register and the controller in place.

module overwrite_byte_fifo_with_blocking_read #(
   parameter int DEPTH    = 256,
   parameter int MAX_READ = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   obfifo_req_if.sink                    req_ch,
   obfifo_rsp_if.source                  rsp_ch,
   input  logic                          csr_we,
   input  logic [obfifo_pkg::CFG_W-1:0]  csr_wdata
);

   obfifo_pkg::cmd_type     cmd;
   obfifo_pkg::dp_stat_type stat;

   obfifo_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_kind     (req_ch.req_type),
      .req_nonblock (req_ch.nonblock),
      .req_ready    (req_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .cmd          (cmd),
      .stat         (stat)
   );

   obfifo_dp #(
      .DEPTH    (DEPTH),
      .MAX_READ (MAX_READ)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .data_byte     (req_ch.data_byte),
      .read_len      (req_ch.read_len),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .status        (rsp_ch.status),
      .out_byte      (rsp_ch.out_byte),
      .last          (rsp_ch.last),
      .used_count    (rsp_ch.used_count),
      .overflow_seen (rsp_ch.overflow_seen)
   );

endmodule
